// ===== rtl/oaht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants and types for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int SLOTS_DEF  = 1024;
	localparam int PROBE_STEP = 331;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 64;
	localparam int CMD_W      = 1;
	localparam int STAT_W     = 2;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [STAT_W-1:0] {
		RESP_OK   = 2'd0,
		RESP_MISS = 2'd1,
		RESP_FULL = 2'd2,
		RESP_ZERO = 2'd3
	} resp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_PROBE,
		S_CHECK
	} state_t;

	typedef struct packed {
		logic  clear;
		logic  load;
		logic  mod_step;
		logic  rd;
		logic  advance;
		logic  write;
		logic  done;
		resp_t resp;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic mod_last;
		logic zero_key;
		logic insert;
		logic empty;
		logic match;
		logic probe_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/oaht_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_datapath
// Key/value stores, probe position arithmetic and result register.
// ----------------------------------------------------------------------------
module oaht_datapath import oaht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  ctrl_cmd_t             cmd,
	output dp_stat_t              stat
);

	localparam int  SPAN   = 2 * SLOTS;
	localparam int  PW     = $clog2(SPAN);
	localparam int  SW     = $clog2(SLOTS);
	localparam int  STEP_R = PROBE_STEP % SPAN;
	localparam bit  POW2   = (SPAN & (SPAN - 1)) == 0;
	localparam int  QSH    = KEY_W - 1 + PW;
	localparam logic [KEY_W-1:0] RECIP  = KEY_W'((64'd1 << QSH) / SPAN);
	localparam logic [PW:0]      SPAN_X = (PW+1)'(SPAN);

	logic [KEY_W-1:0]      key_mem [SLOTS];
	logic [VAL_W-1:0]      val_mem [SLOTS];

	logic [KEY_W-1:0]      key_q;
	logic [VAL_W-1:0]      val_q;
	logic                  ins_q;
	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         cnt_q;
	logic [PW:0]           quo_q;
	logic                  mod_ph_q;
	logic [SW-1:0]         clr_q;
	logic [KEY_W-1:0]      rd_key_q;
	logic [VAL_W-1:0]      rd_val_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [SW-1:0]         slot;
	logic [2*KEY_W-1:0]    quo_prod;
	logic [2*KEY_W-1:0]    quo_shr;
	logic [PW:0]           rem_raw;
	logic [PW-1:0]         mod_next;
	logic [PW:0]           adv_sum;
	logic [PW-1:0]         adv_next;
	logic                  key_we;
	logic [SW-1:0]         key_wa;
	logic [KEY_W-1:0]      key_wd;
	logic [VAL_W-1:0]      found;

	assign slot = pos_q[PW-1:1];

	// quotient estimate by reciprocal is at most one low; one correction step
	assign quo_prod = (2*KEY_W)'(key_q) * (2*KEY_W)'(RECIP);
	assign quo_shr  = quo_prod >> QSH;

	always_comb begin
		rem_raw = key_q[PW:0] - quo_q * SPAN_X;
		if (rem_raw >= SPAN_X) begin
			mod_next = PW'(rem_raw - SPAN_X);
		end else begin
			mod_next = rem_raw[PW-1:0];
		end
	end

	always_comb begin
		adv_sum = {1'b0, pos_q} + (PW+1)'(STEP_R);
		if (adv_sum >= (PW+1)'(SPAN)) begin
			adv_next = PW'(adv_sum - (PW+1)'(SPAN));
		end else begin
			adv_next = adv_sum[PW-1:0];
		end
	end

	assign key_we = cmd.clear || cmd.write;
	assign key_wa = cmd.clear ? clr_q : slot;
	assign key_wd = cmd.clear ? '0 : key_q;

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		if (cmd.rd) begin
			rd_key_q <= key_mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			val_mem[slot] <= val_q;
		end
		if (cmd.rd) begin
			rd_val_q <= val_mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= s_tdata[KEY_W-1:0];
			val_q    <= s_tdata[KEY_W +: VAL_W];
			ins_q    <= s_tuser;
			mod_ph_q <= 1'b0;
			cnt_q    <= '0;
			if (POW2) begin
				pos_q <= s_tdata[PW-1:0];
			end else begin
				pos_q <= '0;
			end
		end else if (cmd.mod_step) begin
			if (!POW2) begin
				if (!mod_ph_q) begin
					quo_q <= quo_shr[PW:0];
				end else begin
					pos_q <= mod_next;
				end
				mod_ph_q <= !mod_ph_q;
			end
		end else if (cmd.advance) begin
			pos_q <= adv_next;
			cnt_q <= cnt_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + SW'(1);
		end
	end

	assign found = (cmd.resp == RESP_OK && !ins_q) ? rd_val_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			m_tdata_q <= {6'd0, found, cmd.resp};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign stat.clear_last = clr_q == SW'(SLOTS - 1);
	assign stat.mod_last   = POW2 ? 1'b1 : mod_ph_q;
	assign stat.zero_key   = key_q == '0;
	assign stat.insert     = ins_q;
	assign stat.empty      = rd_key_q == '0;
	assign stat.match      = rd_key_q == key_q;
	assign stat.probe_last = cnt_q == PW'(SPAN - 1);
	assign stat.out_free   = !m_tvalid_q || m_tready;

endmodule

// ===== rtl/oaht_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer: clearing pass, key reduction, probe read and check.
// ----------------------------------------------------------------------------
module oaht_ctrl import oaht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (stat.zero_key) begin
					if (stat.out_free) begin
						state_d = S_IDLE;
					end
				end else if (stat.mod_last) begin
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.insert) begin
					if (stat.empty || stat.probe_last) begin
						if (stat.out_free) begin
							state_d = S_IDLE;
						end
					end else begin
						state_d = S_PROBE;
					end
				end else begin
					if (stat.match || stat.empty || stat.probe_last) begin
						if (stat.out_free) begin
							state_d = S_IDLE;
						end
					end else begin
						state_d = S_PROBE;
					end
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.resp = RESP_OK;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_MOD: begin
				if (stat.zero_key) begin
					cmd.resp = RESP_ZERO;
					cmd.done = stat.out_free;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			S_PROBE: begin
				cmd.rd = 1'b1;
			end
			S_CHECK: begin
				if (stat.insert) begin
					if (stat.empty) begin
						cmd.resp  = RESP_OK;
						cmd.done  = stat.out_free;
						cmd.write = stat.out_free;
					end else if (stat.probe_last) begin
						cmd.resp = RESP_FULL;
						cmd.done = stat.out_free;
					end else begin
						cmd.advance = 1'b1;
					end
				end else begin
					if (stat.match) begin
						cmd.resp = RESP_OK;
						cmd.done = stat.out_free;
					end else if (stat.empty || stat.probe_last) begin
						cmd.resp = RESP_MISS;
						cmd.done = stat.out_free;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/open_addressing_hash_table.sv =====
`timescale 1ns / 1ps
// Sequence: accept, key reduction (direct for power-of-two 2*SLOTS, else the
// reciprocal quotient then the remainder), then per probe a memory read and a check;
// the result registers at the end of the last check once the output is free (a zero
// key skips the probes). One request in flight; next accept in the cycle after the
// result loads. After reset a clearing pass writes every key slot with s_tready low.
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Fixed-size key/value table with fixed-step open-addressing probes.
// ----------------------------------------------------------------------------
module open_addressing_hash_table import oaht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] key, [95:32] value
	input  logic                  s_tuser,  // [0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // [1:0] status, [65:2] found_value, pad
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	oaht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	oaht_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// ===== dv/open_addressing_hash_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_tb
// Drives search and insert requests into the hash table and checks every
// reply against a behavioral copy of the table kept in the bench. Covers
// zero keys, extreme keys and values, duplicate and colliding keys, random
// traffic, and a fill to capacity with full-table inserts and searches.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_tb;
	import oaht_pkg::*;

	localparam int TABLE_SLOTS  = 1024;
	localparam int PROBE_STRIDE = 331;
	localparam int PROBE_SPAN   = 2 * TABLE_SLOTS;
	localparam bit CMD_SEARCH   = 1'b0;
	localparam bit CMD_INSERT   = 1'b1;
	localparam int IDLE_PCT     = 32;
	localparam int STALL_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 64;

	typedef struct {
		resp_t          status;
		bit [VAL_W-1:0] found;
	} reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	bit [KEY_W-1:0] table_keys [TABLE_SLOTS];
	bit [VAL_W-1:0] table_vals [TABLE_SLOTS];
	bit [KEY_W-1:0] stored_keys [$];
	reply_t         pending_replies [$];

	int tx_idle_pct  = IDLE_PCT;
	int rx_idle_pct  = IDLE_PCT;
	int err_count    = 0;
	int stall_cycles = 0;

	open_addressing_hash_table #(
		.SLOTS(TABLE_SLOTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// probe walk over the bench copy of the table
	function automatic reply_t apply_table_op(bit cmd, bit [KEY_W-1:0] key,
			bit [VAL_W-1:0] val);
		reply_t      r;
		bit [63:0]   pos;
		int unsigned slot;
		r.found = '0;
		if (key == '0) begin
			r.status = RESP_ZERO;
			return r;
		end
		if (cmd == CMD_INSERT)
			r.status = RESP_FULL;
		else
			r.status = RESP_MISS;
		for (int i = 0; i < PROBE_SPAN; i++) begin
			pos  = (64'(key) + 64'(i) * 64'(PROBE_STRIDE)) % 64'(PROBE_SPAN);
			slot = int'(pos >> 1);
			if (cmd == CMD_INSERT) begin
				if (table_keys[slot] == '0) begin
					table_keys[slot] = key;
					table_vals[slot] = val;
					r.status = RESP_OK;
					break;
				end
			end else if (table_keys[slot] == key) begin
				r.status = RESP_OK;
				r.found  = table_vals[slot];
				break;
			end else if (table_keys[slot] == '0) begin
				break;
			end
		end
		return r;
	endfunction

	// mix of zero, stored, small colliding and fully random keys
	function automatic bit [KEY_W-1:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 45 && stored_keys.size() != 0)
			return stored_keys[$urandom_range(stored_keys.size() - 1)];
		if (roll < 75)
			return KEY_W'($urandom_range(4096, 1));
		return $urandom();
	endfunction

	task automatic send_request(input bit cmd, input bit [KEY_W-1:0] key,
			input bit [VAL_W-1:0] val, output resp_t status);
		reply_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {val, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = apply_table_op(cmd, key, val);
		if (cmd == CMD_INSERT && r.status == RESP_OK)
			stored_keys.push_back(key);
		pending_replies.push_back(r);
		status = r.status;
	endtask

	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic test_zero_key();
		resp_t st;
		send_request(CMD_SEARCH, '0, '0, st);
		send_request(CMD_INSERT, '0, '1, st);
	endtask

	task automatic test_field_extremes();
		resp_t st;
		send_request(CMD_SEARCH, 32'd12345, '1, st);
		send_request(CMD_INSERT, 32'hFFFF_FFFF, '1, st);
		send_request(CMD_INSERT, 32'h0000_0001, '0, st);
		send_request(CMD_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, st);
		send_request(CMD_SEARCH, 32'hFFFF_FFFF, '0, st);
		send_request(CMD_SEARCH, 32'h0000_0001, '1, st);
		send_request(CMD_SEARCH, 32'h8000_0000, '0, st);
		// shares its first slot with the all-ones key, then misses
		send_request(CMD_SEARCH, 32'hFFFF_FFFE, '0, st);
	endtask

	task automatic test_duplicate_keys();
		resp_t st;
		send_request(CMD_INSERT, 32'd5, 64'h0123_4567_89AB_CDEF, st);
		send_request(CMD_INSERT, 32'd5, 64'hFEDC_BA98_7654_3210, st);
		send_request(CMD_SEARCH, 32'd5, '0, st);
		send_request(CMD_INSERT, 32'd2053, 64'h5555_AAAA_5555_AAAA, st);
		send_request(CMD_INSERT, 32'd4, 64'hAAAA_5555_AAAA_5555, st);
		send_request(CMD_SEARCH, 32'd2053, '0, st);
		send_request(CMD_SEARCH, 32'd4, '0, st);
	endtask

	task automatic test_random_traffic();
		resp_t st;
		for (int n = 0; n < 650; n++) begin
			if (n == 250)
				wait_for_replies();
			if (n == 400) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (n == 550) begin
				tx_idle_pct = IDLE_PCT;
				rx_idle_pct = IDLE_PCT;
			end
			send_request(bit'($urandom_range(1)), pick_key(), {$urandom(), $urandom()}, st);
		end
	endtask

	task automatic test_fill_to_capacity();
		resp_t st;
		int    guard;
		st    = RESP_OK;
		guard = 0;
		while (st != RESP_FULL && guard < 3000) begin
			if ($urandom_range(9) == 0)
				send_request(CMD_SEARCH, pick_key(), {$urandom(), $urandom()}, st);
			else
				send_request(CMD_INSERT, pick_key(), {$urandom(), $urandom()}, st);
			guard++;
		end
		for (int n = 0; n < 8; n++)
			send_request(CMD_INSERT, $urandom_range(32'hFFFF_FFFF, 1), {$urandom(), $urandom()}, st);
		for (int n = 0; n < 30; n++)
			send_request(CMD_SEARCH, pick_key(), {$urandom(), $urandom()}, st);
		send_request(CMD_INSERT, '0, {$urandom(), $urandom()}, st);
	endtask

	always @(posedge clk)
		m_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected reply: status %0d found_value %h",
					m_tdata[1:0], m_tdata[65:2]);
				err_count++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tdata[1:0] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
					err_count++;
				end
				if (m_tdata[65:2] !== want.found) begin
					$error("found_value: expected %h, actual %h", want.found, m_tdata[65:2]);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("open_addressing_hash_table_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = 1'b0;
		s_tdata  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_zero_key();
		test_field_extremes();
		test_duplicate_keys();
		test_random_traffic();
		test_fill_to_capacity();
		wait_for_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("open_addressing_hash_table_tb: clean");
		else
			$display("open_addressing_hash_table_tb: errors");
		$finish;
	end

endmodule
